>>> src/msp_pkg.sv
// Shared types, constants and a helper function for the music string parser.
package msp_pkg;

    localparam int COUNT_BITS = 10;
    localparam int CAP_BITS   = 10;
    localparam int CMP_BITS   = (COUNT_BITS + 1 > CAP_BITS) ? COUNT_BITS + 1 : CAP_BITS;

    localparam int SLOTS       = 3;
    localparam int SLOT_BITS   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = QPTR_BITS + 1;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(255);
    localparam logic [2:0]          OCT_RESET = 3'd3;
    localparam logic [2:0]          OCT_MAX   = 3'd6;
    localparam logic [2:0]          OCT_MIN   = 3'd1;
    localparam logic [7:0]          LEN_RESET = 8'd1;

    // Character codes the parser reacts to (upper case after folding).
    localparam logic [7:0] CHR_NONE  = 8'h00;
    localparam logic [7:0] CHR_BANG  = 8'h21;
    localparam logic [7:0] CHR_SHARP = 8'h23;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_DOT   = 8'h2E;
    localparam logic [7:0] CHR_0     = 8'h30;
    localparam logic [7:0] CHR_3     = 8'h33;
    localparam logic [7:0] CHR_9     = 8'h39;
    localparam logic [7:0] CHR_A     = 8'h41;
    localparam logic [7:0] CHR_G     = 8'h47;
    localparam logic [7:0] CHR_H     = 8'h48;
    localparam logic [7:0] CHR_I     = 8'h49;
    localparam logic [7:0] CHR_Q     = 8'h51;
    localparam logic [7:0] CHR_S     = 8'h53;
    localparam logic [7:0] CHR_T     = 8'h54;
    localparam logic [7:0] CHR_W     = 8'h57;
    localparam logic [7:0] CHR_X     = 8'h58;
    localparam logic [7:0] CHR_LO_A  = 8'h61;
    localparam logic [7:0] CHR_LO_Z  = 8'h7A;
    localparam logic [7:0] CASE_DIFF = 8'h20;

    localparam logic [7:0] REST_CODE  = 8'h00;
    localparam logic [3:0] DRUM_NIB   = 4'hF;
    localparam logic [7:0] THIRD_MULT = 8'd171;

    typedef struct packed {
        logic [7:0] ch;
        logic       last_char;
    } in_t;

    typedef struct packed {
        logic [7:0]          code;
        logic [7:0]          note_len;
        logic                is_end;
        logic [CAP_BITS-1:0] byte_count;
    } out_t;

    // All results caused by one input character, in delivery order.
    typedef struct packed {
        logic [SLOT_BITS-1:0]  n;
        out_t [SLOTS-1:0]      slot;
    } rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] tone_of(input logic [2:0] idx);
        logic [7:0] t;
        begin
            case (idx)
                3'd0:    t = 8'd9;
                3'd1:    t = 8'd11;
                3'd2:    t = 8'd0;
                3'd3:    t = 8'd2;
                3'd4:    t = 8'd4;
                3'd5:    t = 8'd5;
                3'd6:    t = 8'd7;
                default: t = 8'd0;
            endcase
            return t;
        end
    endfunction

endpackage

>>> src/music_string_parser.sv
// Top level of the music string parser: front end, bundle queue and output stage.
//
// Usage: characters of a music string arrive on the s_ channel, one per
// transaction, each with a flag that marks the final character. The parser
// keeps octave, duration and a held note letter across characters and
// emits note, rest and drum events on the m_ channel, closed by one end
// item that carries the total byte count. After the end item all parser
// state returns to its start values; the capacity register keeps its value.
// The capacity is written on the cfg_ channel, which is always ready, and
// must only be changed while no string is in progress.
// The first result of a character passes through the bundle queue and the
// output register on its way to m_valid. Throughput: one character per cycle,
// as long as each character yields at most one result and the receiver is
// ready; the results of a character that yields two or three go out one at a
// time, and the four-entry bundle queue absorbs short bursts before s_ready drops.
// Reset (synchronous, active low) clears the parser state, empties the
// queue, drops m_valid and sets the capacity to 255. When the receiver
// stalls, the output register holds its item and the queue fills; s_ready
// falls only once the queue is full.
module music_string_parser (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [msp_pkg::CAP_BITS-1:0] cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  msp_pkg::in_t                 s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output msp_pkg::out_t                m_data
);

    msp_pkg::rec_t      push_rec;
    msp_pkg::rec_t      head;
    msp_pkg::q_status_t status;
    logic               push;
    logic               pop;

    // The capacity register accepts a write in every cycle.
    assign cfg_ready = 1'b1;

    // A character is taken whenever the queue has room for its bundle.
    assign s_ready = !status.full;

    msp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_data    (s_data),
        .q_ready   (s_ready),
        .push      (push),
        .push_rec  (push_rec)
    );

    msp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .status   (status),
        .head     (head)
    );

    msp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> src/msp_front.sv
// Front end: capacity register, parser state and per-character event generation.
module msp_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [msp_pkg::CAP_BITS-1:0]     cfg_data,
    input  logic                             s_valid,
    input  msp_pkg::in_t                     s_data,
    input  logic                             q_ready,
    output logic                             push,
    output msp_pkg::rec_t                    push_rec
);

    logic [msp_pkg::CAP_BITS-1:0]   capacity_reg;
    logic [2:0]                     octave_reg, octave_next;
    logic [7:0]                     len_reg, len_next;
    logic                           held_valid_reg, held_valid_next;
    logic [7:0]                     held_tone_reg, held_tone_next;
    logic [msp_pkg::COUNT_BITS-1:0] count_reg, count_next;
    logic                           halted_reg, halted_next;

    logic          fire;
    msp_pkg::out_t cand [4];
    logic [3:0]    cand_v;

    assign fire = s_valid && q_ready;

    always_comb begin
        logic [7:0]                     c;
        logic                           act, bang, sharp, used, chk, handle;
        logic                           hv1;
        logic [7:0]                     tone0;
        logic [msp_pkg::COUNT_BITS-1:0] cnt1, cnt2, cnt3;
        logic [msp_pkg::CMP_BITS-1:0]   cmp_sum, cnt_ext;
        logic [9:0]                     len_x3;
        logic [15:0]                    len_third;
        logic [2:0]                     oct1;
        logic [7:0]                     len1, tone1;
        logic                           ev;
        logic [7:0]                     ev_code;
        logic [2:0]                     n;

        c = s_data.ch;
        if (c >= msp_pkg::CHR_LO_A && c <= msp_pkg::CHR_LO_Z) begin
            c = c - msp_pkg::CASE_DIFF;
        end
        act   = (s_data.ch != msp_pkg::CHR_NONE) && !halted_reg;
        bang  = (s_data.ch == msp_pkg::CHR_BANG);
        sharp = (s_data.ch == msp_pkg::CHR_SHARP);

        // A held letter comes out first, taking a modifier if one follows.
        tone0 = held_tone_reg;
        if (bang) begin
            tone0 = held_tone_reg - 8'd1;
        end else if (sharp) begin
            tone0 = held_tone_reg + 8'd1;
        end
        cand[0].code       = {1'b0, octave_reg, 4'b0000} | tone0;
        cand[0].note_len   = len_reg;
        cand[0].is_end     = 1'b0;
        cand[0].byte_count = '0;
        cand_v[0]          = act && held_valid_reg;
        used               = cand_v[0] && (bang || sharp);
        cnt1 = cand_v[0] ? count_reg + msp_pkg::COUNT_BITS'(2) : count_reg;
        hv1  = held_valid_reg && !cand_v[0];

        chk     = act && !used;
        cmp_sum = msp_pkg::CMP_BITS'(cnt1) + msp_pkg::CMP_BITS'(2);
        handle  = chk && (cmp_sum < msp_pkg::CMP_BITS'(capacity_reg));

        len_x3    = {2'b00, len_reg} + {1'b0, len_reg, 1'b0};
        len_third = 16'(len_reg) * 16'(msp_pkg::THIRD_MULT);

        oct1    = octave_reg;
        len1    = len_reg;
        tone1   = held_tone_reg;
        ev      = 1'b0;
        ev_code = msp_pkg::REST_CODE;
        if (handle) begin
            unique case (c)
                msp_pkg::CHR_T:     len1 = 8'd1;
                msp_pkg::CHR_S:     len1 = 8'd2;
                msp_pkg::CHR_I:     len1 = 8'd4;
                msp_pkg::CHR_Q:     len1 = 8'd8;
                msp_pkg::CHR_H:     len1 = 8'd16;
                msp_pkg::CHR_W:     len1 = 8'd32;
                msp_pkg::CHR_DOT:   len1 = len_x3[8:1];
                msp_pkg::CHR_3:     len1 = {1'b0, len_third[15:9]};
                msp_pkg::CHR_PLUS: begin
                    if (octave_reg < msp_pkg::OCT_MAX) begin
                        oct1 = octave_reg + 3'd1;
                    end
                end
                msp_pkg::CHR_MINUS: begin
                    if (octave_reg > msp_pkg::OCT_MIN) begin
                        oct1 = octave_reg - 3'd1;
                    end
                end
                msp_pkg::CHR_X: begin
                    ev      = 1'b1;
                    ev_code = msp_pkg::REST_CODE;
                end
                default: begin
                    if (c >= msp_pkg::CHR_A && c <= msp_pkg::CHR_G) begin
                        tone1 = msp_pkg::tone_of(3'(c - msp_pkg::CHR_A));
                        hv1   = 1'b1;
                    end else if (c >= msp_pkg::CHR_0 && c <= msp_pkg::CHR_9) begin
                        ev      = 1'b1;
                        ev_code = {msp_pkg::DRUM_NIB, c[3:0]};
                    end
                end
            endcase
        end
        cand[1].code       = ev_code;
        cand[1].note_len   = len1;
        cand[1].is_end     = 1'b0;
        cand[1].byte_count = '0;
        cand_v[1]          = ev;
        cnt2 = ev ? cnt1 + msp_pkg::COUNT_BITS'(2) : cnt1;

        // The final character flushes a held letter unmodified, then ends the run.
        cand[2].code       = {1'b0, oct1, 4'b0000} | tone1;
        cand[2].note_len   = len1;
        cand[2].is_end     = 1'b0;
        cand[2].byte_count = '0;
        cand_v[2]          = s_data.last_char && hv1;
        cnt3 = cand_v[2] ? cnt2 + msp_pkg::COUNT_BITS'(2) : cnt2;

        cnt_ext            = msp_pkg::CMP_BITS'(cnt3);
        cand[3].code       = msp_pkg::REST_CODE;
        cand[3].note_len   = 8'd0;
        cand[3].is_end     = 1'b1;
        cand[3].byte_count = cnt_ext[msp_pkg::CAP_BITS-1:0];
        cand_v[3]          = s_data.last_char;

        push_rec = '0;
        n        = 3'd0;
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i] && n < 3'(msp_pkg::SLOTS)) begin
                push_rec.slot[n[msp_pkg::SLOT_BITS-1:0]] = cand[i];
                n = n + 3'd1;
            end
        end
        push_rec.n = n[msp_pkg::SLOT_BITS-1:0];
        push       = fire && (n != 3'd0);

        if (s_data.last_char) begin
            octave_next     = msp_pkg::OCT_RESET;
            len_next        = msp_pkg::LEN_RESET;
            held_valid_next = 1'b0;
            held_tone_next  = 8'd0;
            count_next      = '0;
            halted_next     = 1'b0;
        end else begin
            octave_next     = oct1;
            len_next        = len1;
            held_valid_next = hv1;
            held_tone_next  = tone1;
            count_next      = cnt2;
            halted_next     = halted_reg || (chk && !handle);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg   <= msp_pkg::CAP_RESET;
            octave_reg     <= msp_pkg::OCT_RESET;
            len_reg        <= msp_pkg::LEN_RESET;
            held_valid_reg <= 1'b0;
            held_tone_reg  <= 8'd0;
            count_reg      <= '0;
            halted_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                capacity_reg <= cfg_data;
            end
            if (fire) begin
                octave_reg     <= octave_next;
                len_reg        <= len_next;
                held_valid_reg <= held_valid_next;
                held_tone_reg  <= held_tone_next;
                count_reg      <= count_next;
                halted_reg     <= halted_next;
            end
        end
    end

endmodule

>>> src/msp_queue.sv
// Short queue of result bundles between the parser front end and the output stage.
module msp_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  msp_pkg::rec_t      push_rec,
    input  logic               pop,
    output msp_pkg::q_status_t status,
    output msp_pkg::rec_t      head
);

    msp_pkg::rec_t                  mem [msp_pkg::QUEUE_DEPTH];
    logic [msp_pkg::QPTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [msp_pkg::QCNT_BITS-1:0]  fill_reg, fill_next;

    assign status.full  = (fill_reg == msp_pkg::QCNT_BITS'(msp_pkg::QUEUE_DEPTH));
    assign status.empty = (fill_reg == '0);
    assign head         = mem[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + msp_pkg::QCNT_BITS'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - msp_pkg::QCNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + msp_pkg::QPTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + msp_pkg::QPTR_BITS'(1);
            end
            fill_reg <= fill_next;
        end
    end

endmodule

>>> src/msp_back.sv
// Back end: unpacks result bundles one item at a time into the output register.
module msp_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  msp_pkg::q_status_t status,
    input  msp_pkg::rec_t      head,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output msp_pkg::out_t      m_data
);

    logic [msp_pkg::SLOT_BITS-1:0] idx_reg, idx_next;
    logic                          m_valid_reg, m_valid_next;
    msp_pkg::out_t                 m_data_reg, m_data_next;
    logic                          load, take, last_slot;

    assign load      = !m_valid_reg || m_ready;
    assign take      = load && !status.empty;
    assign last_slot = (idx_reg == head.n - msp_pkg::SLOT_BITS'(1));
    assign pop       = take && last_slot;

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next = !status.empty;
        end
        if (take) begin
            m_data_next = head.slot[idx_reg];
            idx_next    = last_slot ? '0 : idx_reg + msp_pkg::SLOT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> src/msp_checker.sv
// Port-level checker for the music string parser and its bind statement.
module msp_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input msp_pkg::in_t                 s_data,
    input logic                         m_valid,
    input logic                         m_ready,
    input msp_pkg::out_t                m_data
);

    // A waiting input transaction keeps its payload.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input changed while waiting");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Nothing is shown right after reset, and input is taken again.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("ports not idle after reset");

    // The end item carries no note and an even byte total.
    a_end_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_end |->
            m_data.code == 8'd0 && m_data.note_len == 8'd0 && !m_data.byte_count[0])
        else $error("malformed end item");

    // Event items report no byte count.
    a_event_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_end |-> m_data.byte_count == '0)
        else $error("event item with byte count");

endmodule

bind music_string_parser msp_checker u_msp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> tb/music_string_parser_tb.sv
// Self-checking testbench for the music string parser, with a parse predictor of its own.
`timescale 1ns / 100ps

module music_string_parser_tb;

    // The watchdog limit is far above the slowest correct run. That run is
    // under two hundred characters, each with at most three events, each
    // event held up by occasional receiver stalls.
    localparam int CYCLE_LIMIT   = 200000;
    // The parser answers through its bundle queue and output register. These few cycles cover
    // a character that gives no event but is still in flight.
    localparam int SETTLE_CYCLES = 4;

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [msp_pkg::CAP_BITS-1:0] cfg_data  = '0;
    logic                         s_valid   = 1'b0;
    logic                         s_ready;
    msp_pkg::in_t                 s_data    = '0;
    logic                         m_valid;
    logic                         m_ready   = 1'b0;
    msp_pkg::out_t                m_data;

    // When set, neither side of the data path idles.
    bit steady_flow = 1'b0;

    int cycle_count = 0;
    int error_count = 0;

    // Parser state as the predictor sees it. It is updated when a character
    // is driven, which is safe because a driven character stays on the port
    // until it is accepted.
    logic [2:0]                     oct_now;
    logic [7:0]                     len_now;
    logic                           note_waiting;
    logic [7:0]                     held_pitch;
    logic [msp_pkg::COUNT_BITS-1:0] byte_total;
    logic                           parse_halted;
    logic [msp_pkg::CAP_BITS-1:0]   cap_value;

    // Events that the parser still owes us, oldest first.
    msp_pkg::out_t pending_events[$];

    music_string_parser i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic clear_parser();
        oct_now      = msp_pkg::OCT_RESET;
        len_now      = msp_pkg::LEN_RESET;
        note_waiting = 1'b0;
        held_pitch   = 8'h00;
        byte_total   = '0;
        parse_halted = 1'b0;
    endtask

    // Each event carries the running duration and takes two bytes of room.
    task automatic emit_event(input logic [7:0] code);
        msp_pkg::out_t ev;
        ev.code       = code;
        ev.note_len   = len_now;
        ev.is_end     = 1'b0;
        ev.byte_count = '0;
        pending_events.push_back(ev);
        byte_total = byte_total + msp_pkg::COUNT_BITS'(2);
    endtask

    task automatic emit_note(input logic [7:0] tone);
        emit_event({1'b0, oct_now, 4'h0} | tone);
        note_waiting = 1'b0;
    endtask

    // Works out the events that one character causes and advances the state.
    task automatic parse_char(input msp_pkg::in_t item);
        logic [7:0] c;
        logic [7:0] tone;
        logic [9:0] tripled;
        logic       consumed;
        c = item.ch;
        if (c != msp_pkg::CHR_NONE && !parse_halted) begin
            consumed = 1'b0;
            // A held letter always comes out now. A sharp or flat sign right
            // behind it bends the tone and is used up by the note.
            if (note_waiting) begin
                tone = held_pitch;
                if (c == msp_pkg::CHR_BANG) begin
                    tone = tone - 8'd1;
                    consumed = 1'b1;
                end else if (c == msp_pkg::CHR_SHARP) begin
                    tone = tone + 8'd1;
                    consumed = 1'b1;
                end
                emit_note(tone);
            end
            if (!consumed) begin
                if (int'(byte_total) + 2 >= int'(cap_value)) begin
                    parse_halted = 1'b1;
                end else begin
                    if (c >= msp_pkg::CHR_LO_A && c <= msp_pkg::CHR_LO_Z) begin
                        c = c - msp_pkg::CASE_DIFF;
                    end
                    if (c >= msp_pkg::CHR_A && c <= msp_pkg::CHR_G) begin
                        case (c - msp_pkg::CHR_A)
                            8'd0:    held_pitch = 8'd9;
                            8'd1:    held_pitch = 8'd11;
                            8'd2:    held_pitch = 8'd0;
                            8'd3:    held_pitch = 8'd2;
                            8'd4:    held_pitch = 8'd4;
                            8'd5:    held_pitch = 8'd5;
                            default: held_pitch = 8'd7;
                        endcase
                        note_waiting = 1'b1;
                    end else if (c >= msp_pkg::CHR_0 && c <= msp_pkg::CHR_9
                                 && c != msp_pkg::CHR_3) begin
                        emit_event({msp_pkg::DRUM_NIB, c[3:0]});
                    end else begin
                        case (c)
                            msp_pkg::CHR_T: len_now = 8'd1;
                            msp_pkg::CHR_S: len_now = 8'd2;
                            msp_pkg::CHR_I: len_now = 8'd4;
                            msp_pkg::CHR_Q: len_now = 8'd8;
                            msp_pkg::CHR_H: len_now = 8'd16;
                            msp_pkg::CHR_W: len_now = 8'd32;
                            msp_pkg::CHR_DOT: begin
                                // Times three halves, keeping the low eight bits.
                                tripled = {2'b00, len_now} * 10'd3;
                                len_now = tripled[8:1];
                            end
                            msp_pkg::CHR_3: len_now = len_now / 8'd3;
                            msp_pkg::CHR_PLUS: begin
                                if (oct_now < msp_pkg::OCT_MAX) oct_now = oct_now + 3'd1;
                            end
                            msp_pkg::CHR_MINUS: begin
                                if (oct_now > msp_pkg::OCT_MIN) oct_now = oct_now - 3'd1;
                            end
                            msp_pkg::CHR_X: emit_event(msp_pkg::REST_CODE);
                            default: ;
                        endcase
                    end
                end
            end
        end
        // The end of a string flushes a held letter without modifier, reports
        // the byte total and starts the next string from scratch.
        if (item.last_char) begin
            msp_pkg::out_t done;
            if (note_waiting) emit_note(held_pitch);
            done.code       = 8'h00;
            done.note_len   = 8'h00;
            done.is_end     = 1'b1;
            done.byte_count = byte_total;
            pending_events.push_back(done);
            clear_parser();
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("cycle %0d: %s is %0d, expected %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    // Every event the parser hands over is compared with the oldest one that
    // the predictor still expects.
    always @(posedge aclk) begin : result_check
        msp_pkg::out_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_events.size() == 0) begin
                report_mismatch("code of an event nobody expected", m_data.code, -1);
            end else begin
                want = pending_events.pop_front();
                if (m_data.code !== want.code)
                    report_mismatch("code", m_data.code, want.code);
                if (m_data.note_len !== want.note_len)
                    report_mismatch("note_len", m_data.note_len, want.note_len);
                if (m_data.is_end !== want.is_end)
                    report_mismatch("is_end", m_data.is_end, want.is_end);
                if (m_data.byte_count !== want.byte_count)
                    report_mismatch("byte_count", m_data.byte_count, want.byte_count);
            end
        end
    end

    // The receiver stalls at random, about six percent of the time, except during a
    // steady stretch.
    always @(posedge aclk) begin
        m_ready <= steady_flow || ($urandom_range(99) >= 6);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events outstanding",
                     cycle_count, pending_events.size());
            $display("music_string_parser_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offers one character and returns at the edge where the transaction
    // completes. Valid stays high afterwards, so the next call can keep it
    // up without a gap. Callers that stop sending go through drain_events.
    task automatic send_char(input logic [7:0] ch, input bit last);
        msp_pkg::in_t item;
        item.ch        = ch;
        item.last_char = last;
        if (!steady_flow && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        parse_char(item);
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic send_text(input string text, input bit ends_string);
        for (int i = 0; i < text.len(); i++) begin
            send_char(text[i], ends_string && i == text.len() - 1);
        end
    endtask

    // Stops sending and waits until every expected event has been delivered,
    // plus a few cycles for a character that has no event of its own.
    task automatic drain_events();
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Only called while the parser is idle and between strings.
    task automatic write_capacity(input logic [msp_pkg::CAP_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        cap_value = value;
    endtask

    // Draws one character. Note letters and the two modifiers are favored so
    // that held notes meet their modifiers often. The rest spreads over every
    // command, digits, empty steps and arbitrary bytes.
    function automatic logic [7:0] random_symbol();
        logic [7:0] c;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: c = msp_pkg::CHR_A + 8'($urandom_range(0, 6));
            6, 7:             c = msp_pkg::CHR_BANG;
            8, 9:             c = msp_pkg::CHR_SHARP;
            10, 11: begin
                case ($urandom_range(0, 5))
                    0:       c = msp_pkg::CHR_T;
                    1:       c = msp_pkg::CHR_S;
                    2:       c = msp_pkg::CHR_I;
                    3:       c = msp_pkg::CHR_Q;
                    4:       c = msp_pkg::CHR_H;
                    default: c = msp_pkg::CHR_W;
                endcase
            end
            12:      c = msp_pkg::CHR_DOT;
            13:      c = msp_pkg::CHR_3;
            14:      c = msp_pkg::CHR_PLUS;
            15:      c = msp_pkg::CHR_MINUS;
            16:      c = msp_pkg::CHR_X;
            17:      c = msp_pkg::CHR_0 + 8'($urandom_range(0, 9));
            18:      c = msp_pkg::CHR_NONE;
            default: c = 8'($urandom_range(0, 255));
        endcase
        // Letters come in either case.
        if (c >= msp_pkg::CHR_A && c <= msp_pkg::CHR_X && $urandom_range(0, 1) == 1)
            c = c + msp_pkg::CASE_DIFF;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // A stray modifier, bytes above the ASCII range and empty steps do
    // nothing. An empty step that ends the string still closes it.
    task automatic test_ignored_chars();
        send_char(msp_pkg::CHR_BANG, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(msp_pkg::CHR_NONE, 1'b1);
        drain_events();
    endtask

    // A held letter waits through an empty step and takes a sharp or a flat.
    // Another letter or a rest flushes it unmodified. The octave bottoms out
    // at one. A letter on the final character comes out before the end item.
    task automatic test_notes_and_modifiers();
        send_text("Wc#-d", 1'b0);
        send_char(msp_pkg::CHR_NONE, 1'b0);
        send_text("!--eGx.5B", 1'b1);
        drain_events();
    endtask

    // The duration commands T, I, S, Q and H, division by three, a flat below tone zero that
    // wraps, the octave ceiling, and a sharp that is the final character.
    task automatic test_durations_and_octave_limits();
        send_text("TISQH3c!.++++b#", 1'b1);
        drain_events();
    endtask

    // With room for two events the third one stops the string. The rest is
    // dropped, and only the end item follows. A capacity of zero stops the
    // very first character.
    task automatic test_capacity_halt();
        write_capacity(msp_pkg::CAP_BITS'(6));
        send_text("xxxcd", 1'b1);
        drain_events();
        write_capacity(msp_pkg::CAP_BITS'(0));
        send_text("g", 1'b1);
        drain_events();
    endtask

    // Random strings of one to twelve characters under a given capacity.
    // Every character sent counts toward the item budget. With hold_midway
    // set, the sender stops once halfway until every expected event has
    // arrived.
    task automatic test_random_strings(input logic [msp_pkg::CAP_BITS-1:0] cap,
                                       input int items,
                                       input bit calm, input bit hold_midway);
        int  counted;
        int  len;
        bit  held_done;
        counted   = 0;
        held_done = 1'b0;
        write_capacity(cap);
        steady_flow = calm;
        while (counted < items) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                counted++;
                send_char(random_symbol(), i == len - 1);
                if (hold_midway && !held_done && counted >= items / 2) begin
                    drain_events();
                    held_done = 1'b1;
                end
            end
        end
        drain_events();
        steady_flow = 1'b0;
    endtask

    initial begin
        clear_parser();
        cap_value = msp_pkg::CAP_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_ignored_chars();
        test_notes_and_modifiers();
        test_durations_and_octave_limits();
        test_capacity_halt();

        // Largest capacity with a mid-run pause, then a tight one that keeps
        // halting strings, then a steady stretch at the reset value, then
        // anything in range.
        test_random_strings(msp_pkg::CAP_BITS'(1023), 24, 1'b0, 1'b1);
        test_random_strings(msp_pkg::CAP_BITS'($urandom_range(3, 30)), 24, 1'b0, 1'b0);
        test_random_strings(msp_pkg::CAP_RESET, 18, 1'b1, 1'b0);
        test_random_strings(msp_pkg::CAP_BITS'($urandom_range(0, 1023)), 18, 1'b0, 1'b0);

        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("music_string_parser_tb OK");
        end else begin
            $display("music_string_parser_tb NOT OK");
        end
        $finish;
    end

endmodule
